// File: sv/fast_sqrt_approximation_defines.svh
// Assertion macros of the square root pipeline, used by the multiplier
`ifndef FAST_SQRT_APPROXIMATION_DEFINES_SVH
`define FAST_SQRT_APPROXIMATION_DEFINES_SVH

`define FSA_ASSERT_NOW(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

`define FSA_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/fsa_pkg.sv
// Constants and helpers of the square root pipeline
package fsa_pkg;

  localparam logic [31:0] SEED_MAGIC = 32'h5f3759df;
  localparam logic [31:0] CANON_NAN  = 32'h7fc00000;
  localparam logic [31:0] THREE_HALF = 32'h3fc00000;
  localparam logic [7:0]  EXP_MAX    = 8'hff;

  function automatic logic [31:0] flush_sub(input logic [31:0] f);
    logic [31:0] r;
    r = f;
    if (f[30:23] == 8'd0) begin
      r = {f[31], 31'd0};
    end
    return r;
  endfunction

  function automatic logic is_nan(input logic [31:0] f);
    return (f[30:23] == EXP_MAX) && (f[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(input logic [31:0] f);
    return (f[30:23] == EXP_MAX) && (f[22:0] == 23'd0);
  endfunction

endpackage

// File: sv/fsa_delay.sv
// Two-stage side-data delay matching one arithmetic unit
module fsa_delay import fsa_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] d1;

  always_ff @(posedge clk) begin
    if (en) begin
      d1   <= din;
      dout <= d1;
    end
  end

endmodule

// File: sv/fsa_mul.sv
// Two-stage single-precision multiplier, round to nearest even, flush to zero
`include "fast_sqrt_approximation_defines.svh"
module fsa_mul import fsa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        a_valid,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        res_valid,
  output logic [31:0] res
);

  logic              v1;
  logic              spec1;
  logic [31:0]       sres1;
  logic              s1;
  logic signed [9:0] e1;
  logic [47:0]       p1;

  logic [31:0]       fa, fb;
  logic              spec_c;
  logic [31:0]       sres_c;

  logic [31:0]       res_next;
  logic signed [9:0] e;
  logic [23:0]       mant;
  logic              g, st, up;
  logic [24:0]       m25;

  always_comb begin
    fa = flush_sub(a);
    fb = flush_sub(b);
    spec_c = 1'b1;
    sres_c = {fa[31] ^ fb[31], 31'd0};
    if (is_nan(fa) || is_nan(fb) ||
        (is_inf(fa) && fb[30:23] == 8'd0) || (is_inf(fb) && fa[30:23] == 8'd0)) begin
      sres_c = CANON_NAN;
    end else if (is_inf(fa) || is_inf(fb)) begin
      sres_c = {fa[31] ^ fb[31], EXP_MAX, 23'd0};
    end else if (fa[30:23] == 8'd0 || fb[30:23] == 8'd0) begin
      sres_c = {fa[31] ^ fb[31], 31'd0};
    end else begin
      spec_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      v1        <= a_valid;
      res_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      spec1 <= spec_c;
      sres1 <= sres_c;
      s1    <= fa[31] ^ fb[31];
      e1    <= $signed({2'b00, fa[30:23]}) + $signed({2'b00, fb[30:23]}) - 10'sd127;
      p1    <= {1'b1, fa[22:0]} * {1'b1, fb[22:0]};
      res   <= res_next;
    end
  end

  always_comb begin
    if (p1[47]) begin
      mant = p1[47:24];
      g    = p1[23];
      st   = |p1[22:0];
      e    = e1 + 10'sd1;
    end else begin
      mant = p1[46:23];
      g    = p1[22];
      st   = |p1[21:0];
      e    = e1;
    end
    up  = g & (st | mant[0]);
    m25 = {1'b0, mant} + {24'd0, up};
    if (spec1) begin
      res_next = sres1;
    end else if (e < 10'sd0) begin
      res_next = {s1, 31'd0};
    end else if (e == 10'sd0) begin
      res_next = (mant == 24'hffffff) ? {s1, 8'd1, 23'd0} : {s1, 31'd0};
    end else begin
      if (m25[24]) begin
        res_next = (e + 10'sd1 >= 10'sd255) ? {s1, EXP_MAX, 23'd0}
                                             : {s1, 8'(e + 10'sd1), 23'd0};
      end else begin
        res_next = (e >= 10'sd255) ? {s1, EXP_MAX, 23'd0} : {s1, e[7:0], m25[22:0]};
      end
    end
  end

  `FSA_ASSERT_NOW(mul_no_subnormal, clk, rst, res_valid, !(res[30:23] == 8'd0 && res[22:0] != 23'd0), "subnormal product")
  `FSA_ASSERT_NOW(mul_canon_nan, clk, rst, res_valid && is_nan(res), res == CANON_NAN, "non-canonical NaN")
  `FSA_ASSERT_NEXT(mul_hold, clk, rst, !en, $stable(res_valid) && $stable(res), "stage moved while held")

endmodule

// File: sv/fsa_sub.sv
// Two-stage single-precision subtractor, round to nearest even, flush to zero
module fsa_sub import fsa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        a_valid,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        res_valid,
  output logic [31:0] res
);

  logic              v1;
  logic              spec1;
  logic [31:0]       sres1;
  logic              s1;
  logic [7:0]        e1;
  logic [27:0]       z1;

  logic [31:0]       fa, fb;
  logic              sbn, spec_c, swap, sx, sy;
  logic [31:0]       sres_c;
  logic [7:0]        ex, ey, d;
  logic [26:0]       xext, yext, yal, lostmask;
  logic [27:0]       z_c;

  logic [31:0]       res_next;
  logic [26:0]       n;
  logic [4:0]        lz;
  logic signed [9:0] e;
  logic [23:0]       mant;
  logic              g, st, up;
  logic [24:0]       m25;
  logic signed [9:0] ef;

  always_comb begin
    fa  = flush_sub(a);
    fb  = flush_sub(b);
    sbn = ~fb[31];
    spec_c = 1'b1;
    sres_c = fa;
    if (is_nan(fa) || is_nan(fb) || (is_inf(fa) && is_inf(fb) && fa[31] != sbn)) begin
      sres_c = CANON_NAN;
    end else if (is_inf(fa)) begin
      sres_c = fa;
    end else if (is_inf(fb)) begin
      sres_c = {sbn, EXP_MAX, 23'd0};
    end else if (fa[30:23] == 8'd0 && fb[30:23] == 8'd0) begin
      sres_c = {fa[31] & sbn, 31'd0};
    end else if (fa[30:23] == 8'd0) begin
      sres_c = {sbn, fb[30:0]};
    end else if (fb[30:23] == 8'd0) begin
      sres_c = fa;
    end else begin
      spec_c = 1'b0;
    end
    swap = fb[30:0] > fa[30:0];
    sx   = swap ? sbn : fa[31];
    sy   = swap ? fa[31] : sbn;
    ex   = swap ? fb[30:23] : fa[30:23];
    ey   = swap ? fa[30:23] : fb[30:23];
    xext = swap ? {1'b1, fb[22:0], 3'b000} : {1'b1, fa[22:0], 3'b000};
    yext = swap ? {1'b1, fa[22:0], 3'b000} : {1'b1, fb[22:0], 3'b000};
    d    = ex - ey;
    lostmask = '0;
    if (d >= 8'd27) begin
      yal = 27'd1;
    end else begin
      lostmask = ~({27{1'b1}} << d[4:0]);
      yal = yext >> d[4:0];
      yal[0] = yal[0] | (|(yext & lostmask));
    end
    if (sx == sy) begin
      z_c = {1'b0, xext} + {1'b0, yal};
    end else begin
      z_c = {1'b0, xext} - {1'b0, yal};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      v1        <= a_valid;
      res_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      spec1 <= spec_c;
      sres1 <= sres_c;
      s1    <= sx;
      e1    <= ex;
      z1    <= z_c;
      res   <= res_next;
    end
  end

  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 27; i++) begin
      if (z1[i]) begin
        lz = 5'(26 - i);
      end
    end
    if (z1[27]) begin
      n = {z1[27:2], z1[1] | z1[0]};
      e = $signed({2'b00, e1}) + 10'sd1;
    end else begin
      n = z1[26:0] << lz;
      e = $signed({2'b00, e1}) - $signed({5'd0, lz});
    end
    mant = n[26:3];
    g    = n[2];
    st   = |n[1:0];
    up   = g & (st | mant[0]);
    m25  = {1'b0, mant} + {24'd0, up};
    ef   = m25[24] ? e + 10'sd1 : e;
    if (spec1) begin
      res_next = sres1;
    end else if (z1 == 28'd0) begin
      res_next = 32'd0;
    end else if (ef <= 10'sd0) begin
      res_next = {s1, 31'd0};
    end else if (ef >= 10'sd255) begin
      res_next = {s1, EXP_MAX, 23'd0};
    end else begin
      res_next = {s1, ef[7:0], m25[24] ? m25[23:1] : m25[22:0]};
    end
  end

endmodule

// File: sv/fsa_newton.sv
// One Newton step y * (1.5 - x*y*y) over eight register stages
module fsa_newton import fsa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] x,
  input  logic [31:0] y,
  input  logic [31:0] v,
  output logic        out_valid,
  output logic [31:0] x_out,
  output logic [31:0] y_out,
  output logic [31:0] v_out
);

  logic        va, vb, vc;
  logic [31:0] ta, tb, tc;
  logic [95:0] sa, sb, sc;

  fsa_mul u_mul_xy (.clk, .rst, .en, .a_valid(in_valid), .a(x), .b(y),
                    .res_valid(va), .res(ta));
  fsa_delay #(.W(96)) u_dly_a (.clk, .en, .din({x, y, v}), .dout(sa));

  fsa_mul u_mul_ty (.clk, .rst, .en, .a_valid(va), .a(ta), .b(sa[63:32]),
                    .res_valid(vb), .res(tb));
  fsa_delay #(.W(96)) u_dly_b (.clk, .en, .din(sa), .dout(sb));

  fsa_sub u_sub (.clk, .rst, .en, .a_valid(vb), .a(THREE_HALF), .b(tb),
                 .res_valid(vc), .res(tc));
  fsa_delay #(.W(96)) u_dly_c (.clk, .en, .din(sb), .dout(sc));

  fsa_mul u_mul_yt (.clk, .rst, .en, .a_valid(vc), .a(sc[63:32]), .b(tc),
                    .res_valid(out_valid), .res(y_out));
  fsa_delay #(.W(64)) u_dly_d (.clk, .en, .din({sc[95:64], sc[31:0]}),
                               .dout({x_out, v_out}));

endmodule

// File: sv/fast_sqrt_approximation.sv
// Fast approximate square root of a single-precision word, fully pipelined.
// One word enters per cycle unless the pipeline is held back by root_ready
// low. The path has 19 register stages: one seed stage, two Newton steps of
// eight stages each (three multipliers and one subtractor, two register
// stages per unit), and a final two-stage multiply.
// The whole pipeline advances together; when the result is held back by
// root_ready low, no stage moves and nothing is lost or repeated.
module fast_sqrt_approximation import fsa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        operand_valid,
  output logic        operand_ready,
  input  logic [31:0] operand_bits,
  output logic        root_valid,
  input  logic        root_ready,
  output logic [31:0] root_bits
);

  logic        adv;
  logic        v0;
  logic [31:0] vs0, xs0, ys0;
  logic [31:0] fv, half, x_c;
  logic        n1_valid, n2_valid;
  logic [31:0] n1_x, n1_y, n1_v, n2_x, n2_y, n2_v;

  assign adv           = !root_valid || root_ready;
  assign operand_ready = adv;

  always_comb begin
    fv   = flush_sub(operand_bits);
    half = {fv[31], fv[31:1]};
    if (fv[30:23] == 8'd0 || fv[30:23] == EXP_MAX) begin
      x_c = fv;
    end else if (fv[30:23] == 8'd1) begin
      x_c = (fv[22:0] == 23'h7fffff) ? {fv[31], 8'd1, 23'd0} : {fv[31], 31'd0};
    end else begin
      x_c = {fv[31], fv[30:23] - 8'd1, fv[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= operand_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vs0 <= fv;
      xs0 <= x_c;
      ys0 <= SEED_MAGIC - half;
    end
  end

  fsa_newton u_step1 (.clk, .rst, .en(adv), .in_valid(v0), .x(xs0), .y(ys0), .v(vs0),
                      .out_valid(n1_valid), .x_out(n1_x), .y_out(n1_y), .v_out(n1_v));

  fsa_newton u_step2 (.clk, .rst, .en(adv), .in_valid(n1_valid), .x(n1_x), .y(n1_y),
                      .v(n1_v), .out_valid(n2_valid), .x_out(n2_x), .y_out(n2_y),
                      .v_out(n2_v));

  fsa_mul u_final (.clk, .rst, .en(adv), .a_valid(n2_valid && (n2_x == n2_x)), .a(n2_v),
                   .b(n2_y), .res_valid(root_valid), .res(root_bits));

endmodule
